@@ rtl/vocab_gap_pair_extractor_assert.svh @@
// Assertion shorthands shared by the RTL files of the gap pair extractor.
// Each macro expects the enclosing module to have aclk and aresetn ports.
`ifndef VOCAB_GAP_PAIR_EXTRACTOR_ASSERT_SVH
`define VOCAB_GAP_PAIR_EXTRACTOR_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define VGPE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant check failed");

// Same-cycle implication.
`define VGPE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define VGPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/vgpe_pkg.sv @@
`default_nettype none

package vgpe_pkg;

    localparam int ID_W        = 64;
    localparam int GAP_W       = 4;
    localparam int GAP_MAX     = (1 << GAP_W) - 1;
    localparam int POS_W       = 5;
    localparam int POS_MAX     = (1 << POS_W) - 1;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        REQ_ADD_VOCAB = 2'd0,
        REQ_ADD_SEP   = 2'd1,
        REQ_BEGIN     = 2'd2,
        REQ_ELEMENT   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_PAIR     = 2'd0,
        KIND_SEP_PAIR = 2'd1,
        KIND_FULL     = 2'd2
    } kind_t;

    // An item on its way through the match cells. For elements the two hit
    // flags collect set membership; for loads the flag of the target set
    // means the id was found or stored.
    typedef struct packed {
        req_t              req;
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic              vhit;
        logic              shit;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ID_W-1:0]   subject_high;
        logic [ID_W-1:0]   subject_low;
        logic [ID_W-1:0]   separator_high;
        logic [ID_W-1:0]   separator_low;
        logic [ID_W-1:0]   object_high;
        logic [ID_W-1:0]   object_low;
        logic [ID_W-1:0]   witness_high;
        logic [ID_W-1:0]   witness_low;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/vgpe_match_cell.sv @@
`default_nettype none

module vgpe_match_cell #(
    parameter bit HAS_VOCAB = 1'b1,
    parameter bit HAS_SEP   = 1'b1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic            in_valid,
    input  vgpe_pkg::item_t in_item,
    output logic            out_valid,
    output vgpe_pkg::item_t out_item
);
    import vgpe_pkg::*;

    logic  take;
    logic  v_eq;
    logic  v_free;
    logic  s_eq;
    logic  s_free;
    item_t item_next;
    item_t item_reg;
    logic  valid_reg;

    assign take = advance && in_valid;

    // Slots fill in order along the chain, so the first free slot that a
    // load meets comes after every slot that could hold a duplicate.
    if (HAS_VOCAB) begin : g_vocab
        logic            occ_reg;
        logic [ID_W-1:0] hi_reg;
        logic [ID_W-1:0] lo_reg;
        logic            wr;

        assign v_eq   = occ_reg && (hi_reg == in_item.id_high) && (lo_reg == in_item.id_low);
        assign v_free = !occ_reg;
        assign wr     = take && (in_item.req == REQ_ADD_VOCAB) && !in_item.vhit && !occ_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                occ_reg <= 1'b0;
            end else if (wr) begin
                occ_reg <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (wr) begin
                hi_reg <= in_item.id_high;
                lo_reg <= in_item.id_low;
            end
        end
    end else begin : g_no_vocab
        assign v_eq   = 1'b0;
        assign v_free = 1'b0;
    end

    if (HAS_SEP) begin : g_sep
        logic            occ_reg;
        logic [ID_W-1:0] hi_reg;
        logic [ID_W-1:0] lo_reg;
        logic            wr;

        assign s_eq   = occ_reg && (hi_reg == in_item.id_high) && (lo_reg == in_item.id_low);
        assign s_free = !occ_reg;
        assign wr     = take && (in_item.req == REQ_ADD_SEP) && !in_item.shit && !occ_reg;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                occ_reg <= 1'b0;
            end else if (wr) begin
                occ_reg <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (wr) begin
                hi_reg <= in_item.id_high;
                lo_reg <= in_item.id_low;
            end
        end
    end else begin : g_no_sep
        assign s_eq   = 1'b0;
        assign s_free = 1'b0;
    end

    always_comb begin
        item_next = in_item;
        unique case (in_item.req)
            REQ_ADD_VOCAB: begin
                item_next.vhit = in_item.vhit | v_eq | v_free;
            end
            REQ_ADD_SEP: begin
                item_next.shit = in_item.shit | s_eq | s_free;
            end
            REQ_BEGIN: begin
                item_next = in_item;
            end
            REQ_ELEMENT: begin
                item_next.vhit = in_item.vhit | v_eq;
                item_next.shit = in_item.shit | s_eq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ rtl/vgpe_pair_stage.sv @@
`default_nettype none

`include "vocab_gap_pair_extractor_assert.svh"

module vgpe_pair_stage #(
    parameter int MAX_GAP = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [vgpe_pkg::GAP_W-1:0]    cfg_data,
    input  logic                          tail_valid,
    input  vgpe_pkg::item_t               tail_item,
    output logic                          advance,
    output logic                          head_valid,
    input  logic                          head_ready,
    output vgpe_pkg::result_t             head
);
    import vgpe_pkg::*;

    // Only gaps up to the register's range can ever be selected.
    localparam int GCAP = (MAX_GAP < GAP_MAX) ? MAX_GAP : GAP_MAX;
    localparam int WD   = GCAP + 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW  = $clog2(QUEUE_DEPTH);

    logic [GAP_W-1:0] gap_reg;
    logic [GAP_W-1:0] eg;

    // Window of earlier elements, newest at tap 0.
    logic [ID_W-1:0]  win_hi_reg [WD];
    logic [ID_W-1:0]  win_lo_reg [WD];
    logic [WD-1:0]    win_v_reg;
    logic [WD-1:0]    win_s_reg;
    logic [POS_W-1:0] pos_reg;
    logic [ID_W-1:0]  wit_hi_reg;
    logic [ID_W-1:0]  wit_lo_reg;

    result_t          q_reg [QUEUE_DEPTH];
    result_t          q_next [QUEUE_DEPTH];
    logic [QCW-1:0]   q_cnt_reg;
    logic [QCW-1:0]   q_cnt_next;

    logic             take;
    logic             pop;
    logic             elem;
    logic             full;
    logic             r0v;
    logic             r1v;
    logic [ID_W-1:0]  a_hi;
    logic [ID_W-1:0]  a_lo;
    logic             a_v;
    logic [ID_W-1:0]  b_hi;
    logic [ID_W-1:0]  b_lo;
    logic             b_v;
    result_t          r_first;
    result_t          r_second;
    logic [1:0]       n_push;

    assign advance    = (q_cnt_reg <= QCW'(QUEUE_DEPTH - 2));
    assign take       = advance && tail_valid;
    assign head_valid = (q_cnt_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = q_reg[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= GAP_W'(1);
        end else if (cfg_we) begin
            gap_reg <= cfg_data;
        end
    end

    always_comb begin
        if (gap_reg == '0) begin
            eg = GAP_W'(1);
        end else if (gap_reg > GAP_W'(GCAP)) begin
            eg = GAP_W'(GCAP);
        end else begin
            eg = gap_reg;
        end
    end

    // Tap a holds the element gap places back, tap b the one before it.
    always_comb begin
        a_hi = '0;
        a_lo = '0;
        a_v  = 1'b0;
        b_hi = '0;
        b_lo = '0;
        b_v  = 1'b0;
        for (int k = 0; k < WD; k++) begin
            if (GAP_W'(k + 1) == eg) begin
                a_hi = win_hi_reg[k];
                a_lo = win_lo_reg[k];
                a_v  = win_v_reg[k];
            end
            if (GAP_W'(k) == eg) begin
                b_hi = win_hi_reg[k];
                b_lo = win_lo_reg[k];
                b_v  = win_v_reg[k];
            end
        end
    end

    assign elem = take && (tail_item.req == REQ_ELEMENT) && tail_item.vhit;
    assign r0v  = elem && (pos_reg >= POS_W'(eg)) && a_v;
    assign r1v  = elem && (pos_reg > POS_W'(eg)) && win_s_reg[0] && b_v;
    assign full = take && (((tail_item.req == REQ_ADD_VOCAB) && !tail_item.vhit) ||
                           ((tail_item.req == REQ_ADD_SEP) && !tail_item.shit));

    always_comb begin
        result_t r_pair;
        result_t r_sep;
        result_t r_full;

        r_pair                = '0;
        r_pair.kind           = KIND_PAIR;
        r_pair.subject_high   = a_hi;
        r_pair.subject_low    = a_lo;
        r_pair.object_high    = tail_item.id_high;
        r_pair.object_low     = tail_item.id_low;
        r_pair.witness_high   = wit_hi_reg;
        r_pair.witness_low    = wit_lo_reg;
        r_pair.last           = !r1v;

        r_sep                 = r_pair;
        r_sep.kind            = KIND_SEP_PAIR;
        r_sep.subject_high    = b_hi;
        r_sep.subject_low     = b_lo;
        r_sep.separator_high  = win_hi_reg[0];
        r_sep.separator_low   = win_lo_reg[0];
        r_sep.last            = 1'b1;

        r_full                = '0;
        r_full.kind           = KIND_FULL;
        r_full.last           = 1'b1;

        r_first  = r_pair;
        r_second = r_sep;
        n_push   = 2'd0;
        priority if (full) begin
            r_first = r_full;
            n_push  = 2'd1;
        end else if (r0v) begin
            n_push  = r1v ? 2'd2 : 2'd1;
        end else if (r1v) begin
            r_first = r_sep;
            n_push  = 2'd1;
        end else begin
            n_push  = 2'd0;
        end
    end

    // Result queue: the head stays at entry 0, new results land behind the
    // entries that remain after this cycle's pop.
    always_comb begin
        logic [QCW-1:0] base;
        logic [QCW-1:0] base_1;

        q_next = q_reg;
        base   = q_cnt_reg;
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                q_next[k] = q_reg[k + 1];
            end
            base = q_cnt_reg - QCW'(1);
        end
        base_1 = base + QCW'(1);
        if (n_push != 2'd0) begin
            q_next[base[QIW-1:0]] = r_first;
        end
        if (n_push == 2'd2) begin
            q_next[base_1[QIW-1:0]] = r_second;
        end
        q_cnt_next = base + QCW'(n_push);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_v_reg  <= '0;
            win_s_reg  <= '0;
            pos_reg    <= '0;
            wit_hi_reg <= '0;
            wit_lo_reg <= '0;
        end else if (take) begin
            if (tail_item.req == REQ_BEGIN) begin
                wit_hi_reg <= tail_item.id_high;
                wit_lo_reg <= tail_item.id_low;
                pos_reg    <= '0;
            end else if (tail_item.req == REQ_ELEMENT) begin
                for (int k = WD - 1; k > 0; k--) begin
                    win_v_reg[k] <= win_v_reg[k - 1];
                    win_s_reg[k] <= win_s_reg[k - 1];
                end
                win_v_reg[0] <= tail_item.vhit;
                win_s_reg[0] <= tail_item.shit;
                if (pos_reg != POS_W'(POS_MAX)) begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && (tail_item.req == REQ_ELEMENT)) begin
            for (int k = WD - 1; k > 0; k--) begin
                win_hi_reg[k] <= win_hi_reg[k - 1];
                win_lo_reg[k] <= win_lo_reg[k - 1];
            end
            win_hi_reg[0] <= tail_item.id_high;
            win_lo_reg[0] <= tail_item.id_low;
        end
    end

    `VGPE_ASSERT_ALWAYS(a_queue_bound, q_cnt_reg <= QCW'(QUEUE_DEPTH))
    `VGPE_ASSERT_IMP(a_full_is_last, head_valid && (head.kind == KIND_FULL), head.last)
    `VGPE_ASSERT_IMP(a_pair_no_sep, head_valid && (head.kind == KIND_PAIR),
                     (head.separator_high == '0) && (head.separator_low == '0))

endmodule

`default_nettype wire

@@ rtl/vocab_gap_pair_extractor.sv @@
// Channel   Dir  Handshake              Payload
// s_        in   s_tvalid / s_tready    tdata: id_high, id_low; tuser: req_type
// m_        out  m_tvalid / m_tready    tdata: subject, separator, object, witness
//                                       (each high then low); tuser: kind; tlast: last
// cfg_      in   cfg_valid / cfg_ready  gap (4 bits)
//
// One item is taken per cycle while s_tready is high; each item walks a row of match cells,
// one cell a cycle while the row advances; the row has max(VOCAB_DEPTH, SEPARATOR_DEPTH) cells.
// An element that yields two results puts both on the output, the plain pair first.
// The input stalls only when the four-entry result queue holds more than two items.
// cfg_ready is high only while no item is inside the cell row.
// aresetn (synchronous, active low) empties the sets and the window and sets gap to 1.
`default_nettype none

`include "vocab_gap_pair_extractor_assert.svh"

module vocab_gap_pair_extractor #(
    parameter int VOCAB_DEPTH     = 256,
    parameter int SEPARATOR_DEPTH = 16,
    parameter int MAX_GAP         = 14
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] id_high, [127:64] id_low
    input  logic [7:0]   s_tuser,   // [1:0] req_type, rest zero

    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] subject_high, [127:64] subject_low, [191:128] separator_high,
    // [255:192] separator_low, [319:256] object_high, [383:320] object_low,
    // [447:384] witness_high, [511:448] witness_low
    output logic [511:0] m_tdata,
    output logic [7:0]   m_tuser,   // [1:0] kind, rest zero
    output logic         m_tlast,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data   // [3:0] gap, rest ignored
);
    import vgpe_pkg::*;

    // The cell row is as long as the larger set; a cell carries a vocabulary
    // slot, a separator slot or both, depending on its place.
    localparam int NCELL = (VOCAB_DEPTH > SEPARATOR_DEPTH) ? VOCAB_DEPTH : SEPARATOR_DEPTH;
    localparam int FW    = $clog2(NCELL + 1);

    logic [NCELL:0] chain_valid;
    item_t          chain_item [NCELL+1];
    logic           advance;
    logic           s_acc;
    logic           take;
    logic [FW-1:0]  inflight_reg;
    logic [FW-1:0]  inflight_next;
    result_t        head;

    // A new item enters the first cell with both hit flags clear. When no
    // item is offered, a bubble moves into the row instead.
    always_comb begin
        chain_item[0]         = '0;
        chain_item[0].req     = req_t'(s_tuser[1:0]);
        chain_item[0].id_high = s_tdata[63:0];
        chain_item[0].id_low  = s_tdata[127:64];
    end
    assign chain_valid[0] = s_tvalid;

    // The whole row moves together; every cell sees the item ahead of the
    // one behind it, so loads and lookups stay in arrival order.
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        vgpe_match_cell #(
            .HAS_VOCAB (k < VOCAB_DEPTH),
            .HAS_SEP   (k < SEPARATOR_DEPTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    // The pair stage keeps the window, the position count and the witness,
    // builds the results and queues them for the output.
    vgpe_pair_stage #(
        .MAX_GAP (MAX_GAP)
    ) u_pair (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data[GAP_W-1:0]),
        .tail_valid (chain_valid[NCELL]),
        .tail_item  (chain_item[NCELL]),
        .advance    (advance),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign s_tready = advance;
    assign s_acc    = s_tvalid && s_tready;
    assign take     = advance && chain_valid[NCELL];

    // Items inside the cell row; a gap change waits until the row is empty
    // so that every element sees the gap in force when it was sent.
    assign inflight_next = inflight_reg + FW'(s_acc) - FW'(take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    assign cfg_ready = (inflight_reg == '0);

    assign m_tdata = {head.witness_low,   head.witness_high,
                      head.object_low,    head.object_high,
                      head.separator_low, head.separator_high,
                      head.subject_low,   head.subject_high};
    assign m_tuser = {6'b0, head.kind};
    assign m_tlast = head.last;

    `VGPE_ASSERT_IMP(a_idle_row_empty, inflight_reg == '0, chain_valid[NCELL:1] == '0)
    `VGPE_ASSERT_NEXT(a_accept_counted, s_acc, inflight_reg != '0)
    `VGPE_ASSERT_ALWAYS(a_inflight_bound, inflight_reg <= FW'(NCELL))

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the gapped token pair extractor.
//
// Every item that the block accepts on its input stream is run through a
// predictor kept inside this bench. The predictor holds its own copy of the
// vocabulary set, the separator set, the element window, the position count,
// the witness id and the gap register. It queues the result items that the
// block must produce. A checker compares each accepted output item, field by
// field, with the oldest queued expectation.
//
// The stimulus opens with a short directed sequence. It covers all-zero and
// all-one ids, duplicate loads, elements that arrive before any begin item,
// loads in the middle of a sequence and an element that is in both sets.
// Random sequences follow under several gap settings and idling mixes, with
// the gap extremes among them. The separator table and later the vocabulary
// table are run into their full state. One phase holds the output off for
// a long time so that the block must stall its input.
module testbench;

    import vgpe_pkg::*;

    // An item must pass the whole cell row before its results come out; the row
    // is as long as the larger set, and LATENCY covers it with some margin.
    localparam int LATENCY     = 320;
    localparam int CYCLE_LIMIT = 400000;

    localparam int VOCAB_N   = 256;
    localparam int SEP_N     = 16;
    localparam int GAP_LIMIT = 14;
    localparam int WIN_N     = GAP_LIMIT + 2;
    localparam int POS_TOP   = 31;

    localparam int VPOOL_N = 24;
    localparam int SPOOL_N = 20;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;

    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;   // [63:0] id_high, [127:64] id_low
    logic [7:0]   s_tuser   = '0;   // [1:0] req_type, rest zero

    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // [63:0] subject_high, [127:64] subject_low, [191:128] separator_high,
    // [255:192] separator_low, [319:256] object_high, [383:320] object_low,
    // [447:384] witness_high, [511:448] witness_low
    logic [511:0] m_tdata;
    logic [7:0]   m_tuser;          // [1:0] kind, rest zero
    logic         m_tlast;

    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data  = '0;   // [3:0] gap, rest ignored

    vocab_gap_pair_extractor u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state. The id tables are only read below their counts.
    logic [63:0] voc_hi [VOCAB_N];
    logic [63:0] voc_lo [VOCAB_N];
    int          voc_n = 0;
    logic [63:0] sep_hi [SEP_N];
    logic [63:0] sep_lo [SEP_N];
    int          sep_n = 0;
    logic [63:0] win_hi [WIN_N];
    logic [63:0] win_lo [WIN_N];
    logic [1:0]  win_mark [WIN_N];  // bit 0 vocabulary, bit 1 separator
    int          pos = 0;
    logic [63:0] wit_hi = '0;
    logic [63:0] wit_lo = '0;
    logic [3:0]  gap_q = 4'd1;

    result_t expected_pairs [$];

    // Id pools that random sequences draw from, so that membership hits.
    logic [127:0] vocab_pool [VPOOL_N];
    logic [127:0] sep_pool [SPOOL_N];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    initial begin
        for (int k = 0; k < WIN_N; k++) begin
            win_hi[k]   = '0;
            win_lo[k]   = '0;
            win_mark[k] = 2'b00;
        end
    end

    function automatic logic [127:0] random_id();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic bit is_member(input bit sep_set, input logic [63:0] h,
                                     input logic [63:0] l);
        int n;
        n = sep_set ? sep_n : voc_n;
        for (int k = 0; k < n; k++) begin
            if (sep_set ? (sep_hi[k] == h && sep_lo[k] == l)
                        : (voc_hi[k] == h && voc_lo[k] == l))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Builds a pair from the window: the object is always the newest element
    // and the separator, when present, the one just before it.
    function automatic result_t make_result(input kind_t kind, input int sub,
                                            input bit with_sep);
        result_t r;
        r                = '0;
        r.kind           = kind;
        r.subject_high   = win_hi[sub];
        r.subject_low    = win_lo[sub];
        r.separator_high = with_sep ? win_hi[1] : 64'd0;
        r.separator_low  = with_sep ? win_lo[1] : 64'd0;
        r.object_high    = win_hi[0];
        r.object_low     = win_lo[0];
        r.witness_high   = wit_hi;
        r.witness_low    = wit_lo;
        r.last           = 1'b0;
        return r;
    endfunction

    // Updates the predictor for one accepted item and queues its results.
    task automatic extract_pairs(input req_t req, input logic [127:0] id);
        logic [63:0] h;
        logic [63:0] l;
        bit          sep_set;
        int          g;
        int          n;
        result_t     r;
        result_t     found [2];
        h = id[127:64];
        l = id[63:0];
        case (req)
            REQ_ADD_VOCAB, REQ_ADD_SEP: begin
                sep_set = (req == REQ_ADD_SEP);
                // A duplicate is accepted silently; a new id for a full table
                // is dropped and reported.
                if (!is_member(sep_set, h, l)) begin
                    if (!sep_set && voc_n < VOCAB_N) begin
                        voc_hi[voc_n] = h;
                        voc_lo[voc_n] = l;
                        voc_n++;
                    end else if (sep_set && sep_n < SEP_N) begin
                        sep_hi[sep_n] = h;
                        sep_lo[sep_n] = l;
                        sep_n++;
                    end else begin
                        r      = '0;
                        r.kind = KIND_FULL;
                        r.last = 1'b1;
                        expected_pairs.push_back(r);
                    end
                end
            end
            REQ_BEGIN: begin
                wit_hi = h;
                wit_lo = l;
                pos    = 0;
            end
            default: begin
                for (int k = WIN_N - 1; k > 0; k--) begin
                    win_hi[k]   = win_hi[k-1];
                    win_lo[k]   = win_lo[k-1];
                    win_mark[k] = win_mark[k-1];
                end
                win_hi[0]   = h;
                win_lo[0]   = l;
                win_mark[0] = {is_member(1'b1, h, l), is_member(1'b0, h, l)};
                // A gap of zero acts as one and anything above the window
                // reach acts as the largest gap.
                g = gap_q;
                if (g == 0)
                    g = 1;
                if (g > GAP_LIMIT)
                    g = GAP_LIMIT;
                n = 0;
                if (win_mark[0][0]) begin
                    if (pos >= g && win_mark[g][0]) begin
                        found[n] = make_result(KIND_PAIR, g, 1'b0);
                        n++;
                    end
                    if (pos > g && win_mark[1][1] && win_mark[g+1][0]) begin
                        found[n] = make_result(KIND_SEP_PAIR, g + 1, 1'b1);
                        n++;
                    end
                    if (n > 0)
                        found[n-1].last = 1'b1;
                    for (int k = 0; k < n; k++)
                        expected_pairs.push_back(found[k]);
                end
                if (pos < POS_TOP)
                    pos++;
            end
        endcase
    endtask

    // Offers one item, with random idle cycles ahead of it, and waits until
    // it is taken. Ready is sampled at the falling edge, where it is stable
    // up to the rising edge that completes the handshake.
    task automatic send_item(input req_t req, input logic [127:0] id);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id[63:0], id[127:64]};
        s_tuser  <= {6'b0, req};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        extract_pairs(req, id);
    endtask

    // Stops offering, waits for every queued result and then waits out LATENCY
    // as well, so that loads which produce nothing have also left the block.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_pairs.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // The gap register is only written once the block has gone idle.
    task automatic write_gap(input logic [3:0] value);
        bit         taken;
        logic [3:0] pad;
        drain_results();
        pad = 4'($urandom);
        cfg_valid <= 1'b1;
        cfg_data  <= {pad, value};
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        gap_q = value;
    endtask

    // Mostly pool members, so that pairs and separator triples are common,
    // plus near misses that differ from a vocabulary id in a single bit.
    function automatic logic [127:0] pick_element();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return vocab_pool[$urandom_range(VPOOL_N - 1)];
        if (r < 72)
            return sep_pool[$urandom_range(SPOOL_N - 1)];
        if (r < 86)
            return vocab_pool[$urandom_range(VPOOL_N - 1)] ^
                   (128'd1 << $urandom_range(127));
        return random_id();
    endfunction

    task automatic test_directed();
        logic [127:0] ones;
        logic [127:0] zero;
        logic [127:0] mixed;
        logic [127:0] sep;
        ones  = {128{1'b1}};
        zero  = '0;
        mixed = {64'd0, {64{1'b1}}};
        sep   = {{64{1'b1}}, 64'd0};
        send_item(REQ_ADD_VOCAB, ones);
        send_item(REQ_ADD_VOCAB, zero);
        send_item(REQ_ADD_VOCAB, mixed);
        send_item(REQ_ADD_VOCAB, mixed);        // duplicate
        send_item(REQ_ADD_SEP, sep);
        send_item(REQ_ADD_SEP, sep);            // duplicate
        // Elements ahead of any begin item form a sequence with witness zero.
        send_item(REQ_ELEMENT, ones);
        send_item(REQ_ELEMENT, zero);
        send_item(REQ_BEGIN, random_id());
        send_item(REQ_ELEMENT, mixed);
        send_item(REQ_ELEMENT, sep);
        send_item(REQ_ELEMENT, ones);           // separator triple
        send_item(REQ_ELEMENT, ones);
        // The separator joins the vocabulary while the sequence runs; the
        // mark it already has in the window stays as it was.
        send_item(REQ_ADD_VOCAB, sep);
        send_item(REQ_ELEMENT, sep);
        send_item(REQ_ELEMENT, zero);           // pair and triple together
        send_item(REQ_ELEMENT, mixed ^ 128'd1);
        send_item(REQ_BEGIN, ones);
        send_item(REQ_ELEMENT, zero);
        send_item(REQ_ELEMENT, zero);
        drain_results();
    endtask

    // Loads the pools. The separator pool is larger than its table, so the
    // last few loads are rejected as full.
    task automatic test_pool_loads();
        for (int k = 0; k < VPOOL_N; k++)
            vocab_pool[k] = random_id();
        for (int k = 0; k < SPOOL_N; k++)
            sep_pool[k] = random_id();
        for (int k = 0; k < VPOOL_N; k++)
            send_item(REQ_ADD_VOCAB, vocab_pool[k]);
        send_item(REQ_ADD_VOCAB, sep_pool[0]);
        send_item(REQ_ADD_VOCAB, sep_pool[1]);
        for (int k = 0; k < SPOOL_N; k++)
            send_item(REQ_ADD_SEP, sep_pool[k]);
        send_item(REQ_ADD_SEP, sep_pool[2]);
    endtask

    // Random sequences: mostly elements, some begin items and a few loads
    // in between, which also keep growing the vocabulary.
    task automatic test_sequences(input int n_items, input int begin_pct);
        int r;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 2)
                send_item(REQ_ADD_VOCAB, vocab_pool[$urandom_range(VPOOL_N - 1)]);
            else if (r < 4)
                send_item(REQ_ADD_VOCAB, random_id());
            else if (r < 6)
                send_item(REQ_ADD_SEP, sep_pool[$urandom_range(SPOOL_N - 1)]);
            else if (r < 6 + begin_pct)
                send_item(REQ_BEGIN, random_id());
            else
                send_item(REQ_ELEMENT, pick_element());
        end
    endtask

    // The output is held off for a long stretch while vocabulary elements
    // keep coming. More elements are offered than the cell row and the
    // result queue can hold, so both fill and the input must stall.
    // Afterwards the sender waits for every result before it goes on.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(REQ_BEGIN, random_id());
        hold_left = 600;
        for (int k = 0; k < 265; k++)
            send_item(REQ_ELEMENT, vocab_pool[$urandom_range(VPOOL_N - 1)]);
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_pairs.size() != 0);
        for (int k = 0; k < 10; k++)
            send_item(REQ_ELEMENT, pick_element());
    endtask

    // Fills the vocabulary to the brim; further new ids are rejected and a
    // duplicate at full stays silent.
    task automatic test_vocab_full();
        while (voc_n < VOCAB_N)
            send_item(REQ_ADD_VOCAB, random_id());
        for (int k = 0; k < 4; k++)
            send_item(REQ_ADD_VOCAB, random_id());
        send_item(REQ_ADD_VOCAB, vocab_pool[0]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // The receiver either stalls at random or sits out a requested hold-off.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Output items are checked at the falling edge, where valid, ready and
    // the payload hold the values that the next rising edge accepts.
    always @(negedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pairs.size() == 0) begin
                $error("result item with none expected: kind %0d", m_tuser[1:0]);
                fail_count++;
            end else begin
                want = expected_pairs.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_tuser[1:0]));
                check_field("subject_high", want.subject_high, m_tdata[63:0]);
                check_field("subject_low", want.subject_low, m_tdata[127:64]);
                check_field("separator_high", want.separator_high, m_tdata[191:128]);
                check_field("separator_low", want.separator_low, m_tdata[255:192]);
                check_field("object_high", want.object_high, m_tdata[319:256]);
                check_field("object_low", want.object_low, m_tdata[383:320]);
                check_field("witness_high", want.witness_high, m_tdata[447:384]);
                check_field("witness_low", want.witness_low, m_tdata[511:448]);
                check_field("last", 64'(want.last), 64'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vocab_gap_pair_extractor test failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // The gap stays at its reset value of one for the directed part.
        test_directed();
        test_pool_loads();

        // A gap of zero behaves as one; no idling at all.
        write_gap(4'd0);
        test_sequences(40, 8);

        // Gaps at the top end of the register, with long sequences so that
        // the far end of the window is reached.
        send_idle_pct = 63;
        write_gap(4'd15);
        test_sequences(40, 2);

        send_idle_pct = 0;
        stall_pct     = 63;
        write_gap(4'd14);
        test_sequences(40, 2);

        send_idle_pct = 19;
        stall_pct     = 19;
        write_gap(4'($urandom_range(12) + 2));
        test_sequences(30, 6);

        write_gap(4'd1);
        test_backpressure();

        send_idle_pct = 19;
        stall_pct     = 19;
        test_vocab_full();

        write_gap(4'($urandom_range(15)));
        test_sequences(30, 6);

        drain_results();
        if (fail_count == 0 && expected_pairs.size() == 0) begin
            $display("vocab_gap_pair_extractor test passed");
        end else begin
            $display("vocab_gap_pair_extractor test failed");
        end
        $finish;
    end

endmodule
